FILE: rtl/i2cmw_pkg.sv
package i2cmw_pkg;

  // Default sizes
  localparam int unsigned BufferDepthDef = 32;
  localparam int unsigned FillCountDef   = 129;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Bus actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RELEASE = 3'd4
  } act_e;

  // Result codes
  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_TOO_LONG  = 3'd1,
    RES_ADDR_NACK = 3'd2,
    RES_DATA_NACK = 3'd3,
    RES_OTHER     = 3'd4,
    RES_BUSY      = 3'd5
  } res_e;

  // Bus status codes (status register bits 7..3)
  typedef enum logic [4:0] {
    ST_BUS_ERROR = 5'h00,
    ST_START     = 5'h01,
    ST_REP_START = 5'h02,
    ST_SLA_ACK   = 5'h03,
    ST_SLA_NACK  = 5'h04,
    ST_DATA_ACK  = 5'h05,
    ST_DATA_NACK = 5'h06,
    ST_ARB_LOST  = 5'h07
  } status_e;

  // Input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] byte_position;
    logic [7:0] payload_byte;
    logic [6:0] slave_address;
    logic [7:0] transfer_length;
    logic       stop_at_end_req;
    logic       fill_request;
    logic [7:0] bus_status;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       transfer_done;
    logic [2:0] result_code;
    logic       busy_flag;
  } out_t;

endpackage

FILE: rtl/i2cmw_ram.sv
module i2cmw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/i2cmw_ctrl.sv
module i2cmw_ctrl #(
  parameter int unsigned BufferDepth = i2cmw_pkg::BufferDepthDef,
  parameter int unsigned FillCount   = i2cmw_pkg::FillCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  i2cmw_pkg::in_t                 item_i,
  input  logic [7:0]                     rd_data_i,
  output logic                           we_o,
  output logic [$clog2(BufferDepth)-1:0] waddr_o,
  output logic [$clog2(BufferDepth)-1:0] raddr_o,
  output i2cmw_pkg::out_t                res_o
);
  import i2cmw_pkg::*;

  localparam int unsigned AddrW  = $clog2(BufferDepth);
  localparam logic [8:0]  DepthW = 9'(BufferDepth);
  localparam logic [7:0]  FillW  = 8'(FillCount);

  logic       busy_q, busy_d;
  logic       stop_q, stop_d;
  logic       fill_q, fill_d;
  logic [7:0] sent_q, sent_d;
  logic [7:0] len_q, len_d;
  logic [2:0] err_q, err_d;
  logic [7:0] addr_byte_q, addr_byte_d;

  logic [7:0] pos_ext;
  logic       pos_ok;
  logic [4:0] code;

  assign pos_ext = {3'b000, item_i.byte_position};
  assign pos_ok  = {1'b0, pos_ext} < DepthW;
  assign code    = item_i.bus_status[7:3];

  // Store write: loads only while ready
  assign we_o    = accept_i && (item_i.req_type == REQ_LOAD) && !busy_q && pos_ok;
  assign waddr_o = pos_ext[AddrW-1:0];

  // Decision for one beat
  always_comb begin
    busy_d      = busy_q;
    stop_d      = stop_q;
    fill_d      = fill_q;
    sent_d      = sent_q;
    len_d       = len_q;
    err_d       = err_q;
    addr_byte_d = addr_byte_q;
    res_o       = '0;

    case (item_i.req_type)
      REQ_START: begin
        if ({1'b0, item_i.transfer_length} > DepthW) begin
          res_o.transfer_done = 1'b1;
          res_o.result_code   = RES_TOO_LONG;
        end else if (busy_q) begin
          res_o.transfer_done = 1'b1;
          res_o.result_code   = RES_BUSY;
        end else begin
          busy_d           = 1'b1;
          stop_d           = item_i.stop_at_end_req;
          fill_d           = item_i.fill_request;
          err_d            = RES_OK;
          sent_d           = '0;
          len_d            = item_i.fill_request ? FillW : item_i.transfer_length;
          addr_byte_d      = {item_i.slave_address, 1'b0};
          res_o.bus_action = ACT_START;
        end
      end
      REQ_STATUS: begin
        if (code == ST_BUS_ERROR) begin
          res_o.bus_action = ACT_STOP;
          if (busy_q) begin
            busy_d              = 1'b0;
            err_d               = RES_OTHER;
            res_o.transfer_done = 1'b1;
            res_o.result_code   = RES_OTHER;
          end
        end else if (busy_q) begin
          case (code)
            ST_START, ST_REP_START: begin
              res_o.bus_action = ACT_SEND;
              res_o.tx_byte    = addr_byte_q;
            end
            ST_SLA_ACK, ST_DATA_ACK: begin
              if (sent_q < len_q) begin
                sent_d           = sent_q + 8'd1;
                res_o.bus_action = ACT_SEND;
                res_o.tx_byte    = rd_data_i;
              end else begin
                busy_d              = 1'b0;
                res_o.bus_action    = stop_q ? ACT_STOP : ACT_NONE;
                res_o.transfer_done = 1'b1;
                res_o.result_code   = err_q;
              end
            end
            ST_SLA_NACK: begin
              busy_d              = 1'b0;
              err_d               = RES_ADDR_NACK;
              res_o.bus_action    = ACT_STOP;
              res_o.transfer_done = 1'b1;
              res_o.result_code   = RES_ADDR_NACK;
            end
            ST_DATA_NACK: begin
              busy_d              = 1'b0;
              err_d               = RES_DATA_NACK;
              res_o.bus_action    = ACT_STOP;
              res_o.transfer_done = 1'b1;
              res_o.result_code   = RES_DATA_NACK;
            end
            ST_ARB_LOST: begin
              busy_d              = 1'b0;
              err_d               = RES_OTHER;
              res_o.bus_action    = ACT_RELEASE;
              res_o.transfer_done = 1'b1;
              res_o.result_code   = RES_OTHER;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    res_o.busy_flag = busy_d;
  end

  // Prefetch the byte the next ack would send; store read is registered
  always_comb begin
    if (!accept_i) begin
      raddr_o = (sent_q == 8'd0) ? '0 :
                fill_q           ? AddrW'(1) : sent_q[AddrW-1:0];
    end else begin
      raddr_o = (sent_d == 8'd0) ? '0 :
                fill_d           ? AddrW'(1) : sent_d[AddrW-1:0];
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stop_q      <= 1'b1;
      fill_q      <= 1'b0;
      sent_q      <= '0;
      len_q       <= '0;
      err_q       <= RES_OK;
      addr_byte_q <= '0;
    end else if (accept_i) begin
      busy_q      <= busy_d;
      stop_q      <= stop_d;
      fill_q      <= fill_d;
      sent_q      <= sent_d;
      len_q       <= len_d;
      err_q       <= err_d;
      addr_byte_q <= addr_byte_d;
    end
  end

endmodule

FILE: rtl/i2c_master_write_sequencer.sv
// I2C master write sequencer.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per request:
// a buffer load, a start request, or a bus status event from the I2C controller.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives exactly one result
// beat per input beat: the bus action to take, the byte to send, done and
// result code, and the busy flag after the request.
// A result is valid the cycle after its input beat is accepted.
// Throughput is one beat per cycle while the receiver does not stall; the payload
// buffer is a RAM whose registered read always holds the byte the next ack sends.
// Reset leaves the block ready (not busy), stop-after-last-byte set, and the
// buffer contents undefined until loaded.
// When the receiver stalls, the result register holds its beat and in_ready_o
// drops, so no new request is taken until the held result is taken; input is
// accepted in the same cycle the held result leaves.
module i2c_master_write_sequencer #(
  parameter int unsigned BUFFER_DEPTH = i2cmw_pkg::BufferDepthDef,
  parameter int unsigned FILL_COUNT   = i2cmw_pkg::FillCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  i2cmw_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i2cmw_pkg::out_t out_data_o
);
  import i2cmw_pkg::*;

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic             accept;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rd_data;
  out_t             res;
  out_t             out_q;
  logic             out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Payload buffer
  i2cmw_ram #(
    .Width(8),
    .Depth(BUFFER_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.payload_byte),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  // Transfer control
  i2cmw_ctrl #(
    .BufferDepth(BUFFER_DEPTH),
    .FillCount  (FILL_COUNT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .rd_data_i(rd_data),
    .we_o     (we),
    .waddr_o  (waddr),
    .raddr_o  (raddr),
    .res_o    (res)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/sv/tb_i2c_master_write_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_master_write_sequencer;
  import i2cmw_pkg::*;

  // status code with nothing to report (raw 0xF8)
  localparam logic [4:0] ST_NO_INFO = 5'h1F;
  // cycles without any beat before the run is declared hung
  localparam int unsigned HangLimit = 5000;
  localparam int unsigned PhaseItems = 250;

  // Predicts the result of every request and checks the result beats in order
  class xfer_scoreboard;
    logic        busy;
    logic        stop_at_end;
    logic        fill_mode;
    logic [7:0]  sent_count;
    logic [7:0]  send_length;
    res_e        error_kind;
    logic [7:0]  address_byte;
    logic [7:0]  payload_mem [BufferDepthDef];
    out_t        expected_actions [$];
    int unsigned mismatches;

    function new();
      busy         = 1'b0;
      stop_at_end  = 1'b1;
      fill_mode    = 1'b0;
      sent_count   = '0;
      send_length  = '0;
      error_kind   = RES_OK;
      address_byte = '0;
      mismatches   = 0;
      foreach (payload_mem[i]) payload_mem[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_actions.size();
    endfunction

    // transfer ends: back to ready with an action and a result
    function void close_transfer(inout out_t r, input act_e a, input res_e c);
      busy            = 1'b0;
      r.bus_action    = a;
      r.transfer_done = 1'b1;
      r.result_code   = c;
    endfunction

    function out_t next_action(in_t b);
      out_t       r;
      logic [4:0] code;
      logic [7:0] tx;
      r    = '0;
      code = b.bus_status[7:3];
      case (b.req_type)
        REQ_LOAD: begin
          // loads while busy are dropped so bytes in flight stay intact
          if (!busy && b.byte_position < BufferDepthDef)
            payload_mem[b.byte_position] = b.payload_byte;
        end
        REQ_START: begin
          if (b.transfer_length > BufferDepthDef) begin
            r.transfer_done = 1'b1;
            r.result_code   = RES_TOO_LONG;
          end else if (busy) begin
            r.transfer_done = 1'b1;
            r.result_code   = RES_BUSY;
          end else begin
            busy         = 1'b1;
            stop_at_end  = b.stop_at_end_req;
            fill_mode    = b.fill_request;
            error_kind   = RES_OK;
            sent_count   = '0;
            send_length  = b.fill_request ? 8'(FillCountDef) : b.transfer_length;
            address_byte = {b.slave_address, 1'b0};
            r.bus_action = ACT_START;
          end
        end
        REQ_STATUS: begin
          if (code == ST_BUS_ERROR) begin
            // a bus error always frees the bus, even when idle
            if (busy) begin
              error_kind = RES_OTHER;
              close_transfer(r, ACT_STOP, RES_OTHER);
            end else begin
              r.bus_action = ACT_STOP;
            end
          end else if (busy) begin
            case (code)
              ST_START, ST_REP_START: begin
                r.bus_action = ACT_SEND;
                r.tx_byte    = address_byte;
              end
              ST_SLA_ACK, ST_DATA_ACK: begin
                if (sent_count < send_length) begin
                  if (sent_count == 0)  tx = payload_mem[0];
                  else if (fill_mode)   tx = payload_mem[1];
                  else                  tx = payload_mem[sent_count[4:0]];
                  sent_count   = sent_count + 8'd1;
                  r.bus_action = ACT_SEND;
                  r.tx_byte    = tx;
                end else begin
                  close_transfer(r, act_e'(stop_at_end ? ACT_STOP : ACT_NONE),
                                 error_kind);
                end
              end
              ST_SLA_NACK: begin
                error_kind = RES_ADDR_NACK;
                close_transfer(r, ACT_STOP, RES_ADDR_NACK);
              end
              ST_DATA_NACK: begin
                error_kind = RES_DATA_NACK;
                close_transfer(r, ACT_STOP, RES_DATA_NACK);
              end
              ST_ARB_LOST: begin
                error_kind = RES_OTHER;
                close_transfer(r, ACT_RELEASE, RES_OTHER);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      r.busy_flag = busy;
      return r;
    endfunction

    function void note_request(in_t b);
      expected_actions.push_back(next_action(b));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_actions.size() == 0) begin
        $error("result beat with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_actions.pop_front();
      if (got.bus_action !== want.bus_action) begin
        $error("bus_action: expected %0d, got %0d", want.bus_action, got.bus_action);
        mismatches++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
        mismatches++;
      end
      if (got.transfer_done !== want.transfer_done) begin
        $error("transfer_done: expected %0d, got %0d", want.transfer_done, got.transfer_done);
        mismatches++;
      end
      if (got.result_code !== want.result_code) begin
        $error("result_code: expected %0d, got %0d", want.result_code, got.result_code);
        mismatches++;
      end
      if (got.busy_flag !== want.busy_flag) begin
        $error("busy_flag: expected %0d, got %0d", want.busy_flag, got.busy_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  xfer_scoreboard sb = new();
  in_t            stim_q [$];
  int unsigned    src_idle_pct;
  int unsigned    sink_stall_pct;
  int unsigned    quiet_cycles;

  i2c_master_write_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  // receiver: random stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // hang detection: no beat on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // beat builders; unused fields are random so every bit toggles
  function automatic in_t rand_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic in_t load_beat(logic [4:0] pos, logic [7:0] data);
    in_t b;
    b               = rand_beat();
    b.req_type      = REQ_LOAD;
    b.byte_position = pos;
    b.payload_byte  = data;
    return b;
  endfunction

  function automatic in_t start_beat(logic [6:0] addr, logic [7:0] len, logic stop,
                                     logic fill);
    in_t b;
    b                 = rand_beat();
    b.req_type        = REQ_START;
    b.slave_address   = addr;
    b.transfer_length = len;
    b.stop_at_end_req = stop;
    b.fill_request    = fill;
    return b;
  endfunction

  function automatic in_t status_beat(logic [4:0] code);
    in_t b;
    b            = rand_beat();
    b.req_type   = REQ_STATUS;
    b.bus_status = {code, 3'($urandom_range(7))};
    return b;
  endfunction

  // one input beat, with random sender gaps ahead of it
  task automatic drive_beat(input in_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b);
  endtask

  // send everything queued, then hold off until all results are back
  task automatic run_queue();
    foreach (stim_q[i]) drive_beat(stim_q[i]);
    stim_q.delete();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // a mostly well-formed write transfer with occasional noise and early errors
  task automatic queue_transfer();
    int unsigned len;
    int unsigned n;
    int unsigned r;
    logic        fill;
    logic [4:0]  err_code;
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 4))
        stim_q.push_back(load_beat(5'($urandom_range(31)), 8'($urandom_range(255))));
    fill = ($urandom_range(14) == 0);
    if ($urandom_range(9) == 0)      len = $urandom_range(33, 255);
    else if ($urandom_range(3) == 0) len = $urandom_range(0, 32);
    else                             len = $urandom_range(0, 6);
    stim_q.push_back(start_beat(7'($urandom_range(127)), 8'(len),
                                1'($urandom_range(1)), fill));
    stim_q.push_back(status_beat($urandom_range(1) ? ST_START : ST_REP_START));
    // address ack, then one data ack per byte; the last ack ends the transfer
    n = fill ? FillCountDef + 1 : len + 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        case ($urandom_range(3))
          0:       err_code = ST_SLA_NACK;
          1:       err_code = ST_DATA_NACK;
          2:       err_code = ST_ARB_LOST;
          default: err_code = ST_BUS_ERROR;
        endcase
        stim_q.push_back(status_beat(err_code));
        return;
      end
      if (r < 6) stim_q.push_back(rand_beat());
      else if (r < 8) stim_q.push_back(status_beat(5'($urandom_range(8, 31))));
      stim_q.push_back(status_beat(i == 0 ? ST_SLA_ACK : ST_DATA_ACK));
    end
  endtask

  task automatic random_phase(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    while (stim_q.size() < PhaseItems) queue_transfer();
    run_queue();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fill every buffer slot so no acknowledge ever reads an unwritten byte
    stim_q.push_back(load_beat(5'd0, 8'hFF));
    stim_q.push_back(load_beat(5'd1, 8'h00));
    for (int i = 2; i < BufferDepthDef; i++)
      stim_q.push_back(load_beat(i[4:0], 8'($urandom_range(255))));

    // directed: idle events, length limits, busy rejects, every ending
    stim_q.push_back(status_beat(ST_BUS_ERROR));          // bus error while ready
    stim_q.push_back(status_beat(ST_SLA_ACK));            // ignored while ready
    stim_q.push_back(start_beat(7'h7F, 8'd33, 1'b1, 1'b0));  // too long
    stim_q.push_back(start_beat(7'h7F, 8'hFF, 1'b1, 1'b0));  // too long
    stim_q.push_back(start_beat(7'h7F, 8'd2, 1'b1, 1'b0));
    stim_q.push_back(load_beat(5'd31, 8'h5A));            // load while busy
    stim_q.push_back(start_beat(7'h00, 8'd0, 1'b0, 1'b0));   // start while busy
    stim_q.push_back(status_beat(ST_START));
    stim_q.push_back(status_beat(ST_NO_INFO));
    stim_q.push_back(status_beat(5'h09));                 // unknown code
    stim_q.push_back(status_beat(ST_SLA_ACK));
    stim_q.push_back(status_beat(ST_REP_START));
    stim_q.push_back(status_beat(ST_DATA_ACK));
    stim_q.push_back(status_beat(ST_DATA_ACK));           // all out, stop
    begin
      in_t none_beat;
      none_beat          = rand_beat();
      none_beat.req_type = REQ_NONE;
      stim_q.push_back(none_beat);
    end
    stim_q.push_back(start_beat(7'h00, 8'd0, 1'b0, 1'b0));
    stim_q.push_back(status_beat(ST_START));
    stim_q.push_back(status_beat(ST_SLA_ACK));            // end without stop
    stim_q.push_back(start_beat(7'h55, 8'd32, 1'b1, 1'b0));
    stim_q.push_back(status_beat(ST_SLA_NACK));
    stim_q.push_back(start_beat(7'h2A, 8'd1, 1'b1, 1'b0));
    stim_q.push_back(status_beat(ST_SLA_ACK));
    stim_q.push_back(status_beat(ST_DATA_NACK));
    stim_q.push_back(start_beat(7'h2A, 8'd1, 1'b1, 1'b1));
    stim_q.push_back(status_beat(ST_ARB_LOST));
    stim_q.push_back(start_beat(7'h2A, 8'd1, 1'b0, 1'b0));
    stim_q.push_back(status_beat(ST_BUS_ERROR));          // bus error while busy
    run_queue();

    // random phases with different idle patterns
    random_phase(0, 0);
    random_phase(65, 0);
    random_phase(0, 65);
    random_phase(38, 38);

    // drain: nothing outstanding, then a few more cycles
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
